### design/mtvp_pkg.sv
// shared constants and types for the transposed matrix-vector product block
// no dependencies
package mtvp_pkg;

   localparam int MaxSize   = 8192;
   localparam int IdxW      = $clog2(MaxSize);
   localparam int SizeW     = 14;
   localparam int DataW     = 32;
   localparam int OutqDepth = 4;
   localparam int OutqPtrW  = $clog2(OutqDepth);
   localparam int OutqCntW  = OutqPtrW + 1;

   typedef logic [IdxW-1:0]  idx_type;
   typedef logic [DataW-1:0] word_type;

   // one accepted element as handed from the sequencer to the mac pipeline
   typedef struct packed {
      logic     valid;
      idx_type  col;
      logic     first_row;
      logic     last_row;
      logic     last_col;
      word_type a;
      word_type x;
   } issue_type;

   typedef struct packed {
      idx_type                 column_index;
      logic signed [DataW-1:0] dot_value;
      logic                    last_result;
   } result_type;

endpackage

### design/mtvp_intf.sv
// channel interfaces: element input, result output and size register write
// depends on mtvp_pkg
interface mtvp_req_if import mtvp_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [DataW-1:0] matrix_value;
   logic signed [DataW-1:0] vector_value;

   modport source (output valid, output matrix_value, output vector_value, input ready);
   modport sink (input valid, input matrix_value, input vector_value, output ready);
endinterface

interface mtvp_rsp_if import mtvp_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [IdxW-1:0]         column_index;
   logic signed [DataW-1:0] dot_value;
   logic                    last_result;

   modport source (output valid, output column_index, output dot_value,
                   output last_result, input ready);
   modport sink (input valid, input column_index, input dot_value,
                 input last_result, output ready);
endinterface

interface mtvp_csr_if import mtvp_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [SizeW-1:0] size_in_use;

   modport source (output valid, output size_in_use, input ready);
   modport sink (input valid, input size_in_use, output ready);
endinterface

### design/mtvp_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module mtvp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic                                          rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/mtvp_seq.sv
// row and column sequencer: size register, position counters, held vector element
// depends on mtvp_pkg and mtvp_csr_if
module mtvp_seq import mtvp_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   mtvp_csr_if.sink                csr_ch,
   input  logic                    accept,
   input  logic signed [DataW-1:0] matrix_value,
   input  logic signed [DataW-1:0] vector_value,
   output issue_type               issue
);

   idx_type  col_ff, col_in;
   idx_type  row_ff, row_in;
   idx_type  last_ff, last_in;
   word_type held_ff, held_in;
   logic     csr_wr;
   idx_type  new_last;

   assign csr_ch.ready = 1'b1;
   assign csr_wr       = csr_ch.valid;

   // clamp the written size to 1..max and keep size minus one as the last index
   always_comb begin
      if (csr_ch.size_in_use == '0) begin
         new_last = '0;
      end else if (csr_ch.size_in_use > SizeW'(MaxSize)) begin
         new_last = IdxW'(MaxSize - 1);
      end else begin
         new_last = IdxW'(csr_ch.size_in_use - SizeW'(1));
      end
   end

   always_comb begin
      issue.valid     = accept;
      issue.col       = col_ff;
      issue.first_row = (row_ff == '0);
      issue.last_row  = (row_ff == last_ff);
      issue.last_col  = (col_ff == last_ff);
      issue.a         = word_type'(matrix_value);
      issue.x         = (col_ff == '0) ? word_type'(vector_value) : held_ff;
   end

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      last_in = last_ff;
      held_in = held_ff;
      if (csr_wr) begin
         col_in  = '0;
         row_in  = '0;
         last_in = new_last;
      end else if (accept) begin
         held_in = issue.x;
         if (issue.last_col) begin
            col_in = '0;
            row_in = issue.last_row ? '0 : row_ff + IdxW'(1);
         end else begin
            col_in = col_ff + IdxW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         last_ff <= IdxW'(MaxSize - 1);
         held_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         last_ff <= last_in;
         held_ff <= held_in;
      end
   end

endmodule

### design/mtvp_mac.sv
// multiply-accumulate pipeline around the column accumulator ram, with write forwarding
// depends on mtvp_pkg and mtvp_ram
module mtvp_mac import mtvp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  issue_type  issue,
   output logic       res_valid,
   output result_type res,
   output logic [1:0] inflight
);

   issue_type s1_ff;
   logic      s2_valid_ff;
   idx_type   s2_col_ff;
   logic      s2_first_ff;
   logic      s2_last_row_ff;
   logic      s2_last_col_ff;
   word_type  s2_prod_ff, s2_prod_in;
   word_type  s2_base_ff, s2_base_in;
   logic      wr_valid_ff;
   idx_type   wr_col_ff;
   word_type  wr_data_ff;
   word_type  ram_rd_data;
   word_type  acc;

   mtvp_ram #(
      .WIDTH (DataW),
      .DEPTH (MaxSize)
   ) u_sums (
      .clock   (clock),
      .wr_en   (s2_valid_ff),
      .wr_addr (s2_col_ff),
      .wr_data (acc),
      .rd_en   (issue.valid && !issue.first_row),
      .rd_addr (issue.col),
      .rd_data (ram_rd_data)
   );

   assign s2_prod_in = s1_ff.a * s1_ff.x;

   // newest write to the same column wins over the ram data
   always_comb begin
      if (s2_valid_ff && (s2_col_ff == s1_ff.col)) begin
         s2_base_in = acc;
      end else if (wr_valid_ff && (wr_col_ff == s1_ff.col)) begin
         s2_base_in = wr_data_ff;
      end else begin
         s2_base_in = ram_rd_data;
      end
   end

   assign acc = s2_first_ff ? s2_prod_ff : (s2_base_ff + s2_prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_valid_ff <= 1'b0;
         wr_valid_ff <= 1'b0;
      end else begin
         s1_ff.valid <= issue.valid;
         s2_valid_ff <= s1_ff.valid;
         wr_valid_ff <= s2_valid_ff;
      end
      s1_ff.col       <= issue.col;
      s1_ff.first_row <= issue.first_row;
      s1_ff.last_row  <= issue.last_row;
      s1_ff.last_col  <= issue.last_col;
      s1_ff.a         <= issue.a;
      s1_ff.x         <= issue.x;
      s2_col_ff       <= s1_ff.col;
      s2_first_ff     <= s1_ff.first_row;
      s2_last_row_ff  <= s1_ff.last_row;
      s2_last_col_ff  <= s1_ff.last_col;
      s2_prod_ff      <= s2_prod_in;
      s2_base_ff      <= s2_base_in;
      wr_col_ff       <= s2_col_ff;
      wr_data_ff      <= acc;
   end

   assign res_valid        = s2_valid_ff && s2_last_row_ff;
   assign res.column_index = s2_col_ff;
   assign res.dot_value    = acc;
   assign res.last_result  = s2_last_col_ff;

   assign inflight = {1'b0, s1_ff.valid && s1_ff.last_row}
                   + {1'b0, s2_valid_ff && s2_last_row_ff};

endmodule

### design/mtvp_outq.sv
// small result queue that decouples the pipeline from the result channel
// depends on mtvp_pkg and mtvp_rsp_if
module mtvp_outq import mtvp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  result_type          push_data,
   mtvp_rsp_if.source          rsp_ch,
   output logic [OutqCntW-1:0] count
);

   result_type            slot_ff [OutqDepth];
   logic [OutqPtrW-1:0]   wr_ptr_ff;
   logic [OutqPtrW-1:0]   rd_ptr_ff;
   logic [OutqCntW-1:0]   count_ff;
   logic                  pop;
   result_type            head;

   assign head                = slot_ff[rd_ptr_ff];
   assign rsp_ch.valid        = (count_ff != '0);
   assign rsp_ch.column_index = head.column_index;
   assign rsp_ch.dot_value    = head.dot_value;
   assign rsp_ch.last_result  = head.last_result;
   assign pop                 = rsp_ch.valid && rsp_ch.ready;
   assign count               = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + OutqPtrW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + OutqPtrW'(1);
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + OutqCntW'(1);
            2'b01:   count_ff <= count_ff - OutqCntW'(1);
            default: count_ff <= count_ff;
         endcase
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### design/matrix_transpose_vector_product_top.sv
// transposed matrix-vector product: one matrix element per transaction, one column sum out
// a finished column sum is registered in the mac stages s1 and s2, then in the result queue
// throughput: one element per cycle while the queue has credit, paced by the one read
//   and one write per cycle of the column accumulator ram; size n needs n*n elements
// reset: synchronous; counters and held vector cleared, size back to 8192, queue emptied;
//   the accumulator ram is not cleared since row 0 always overwrites it
module matrix_transpose_vector_product_top import mtvp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   mtvp_req_if.sink    req_ch,
   mtvp_rsp_if.source  rsp_ch,
   mtvp_csr_if.sink    csr_ch
);

   issue_type            issue;
   logic                 accept;
   logic                 res_valid;
   result_type           res;
   logic [1:0]           inflight;
   logic [OutqCntW-1:0]  outq_count;
   logic [OutqCntW-1:0]  occupancy;

   // credit check: every result already in the pipeline must find a queue slot
   assign occupancy    = outq_count + OutqCntW'(inflight);
   assign req_ch.ready = (occupancy < OutqCntW'(OutqDepth));
   assign accept       = req_ch.valid && req_ch.ready;

   // position counters, size register and held vector element
   mtvp_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .csr_ch       (csr_ch),
      .accept       (accept),
      .matrix_value (req_ch.matrix_value),
      .vector_value (req_ch.vector_value),
      .issue        (issue)
   );

   // multiply, read-modify-write of the column sum
   mtvp_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .issue     (issue),
      .res_valid (res_valid),
      .res       (res),
      .inflight  (inflight)
   );

   // finished sums wait here for the result channel
   mtvp_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .rsp_ch    (rsp_ch),
      .count     (outq_count)
   );

   // the queue never receives a result it has no room for
   assert property (@(posedge clock) disable iff (reset)
      res_valid |-> ((outq_count < OutqCntW'(OutqDepth)) || rsp_ch.ready))
      else $error("result queue overflow");

   // the last column of a row wraps the column counter back to zero
   assert property (@(posedge clock) disable iff (reset)
      (issue.valid && issue.last_col && !csr_ch.valid) |=> (issue.col == '0))
      else $error("column counter did not wrap");

   // any other transaction steps the column counter by one
   assert property (@(posedge clock) disable iff (reset)
      (issue.valid && !issue.last_col && !csr_ch.valid)
         |=> (issue.col == $past(issue.col) + IdxW'(1)))
      else $error("column counter did not advance");

endmodule

### verif/tb_matrix_transpose_vector_product_top.sv
// testbench for the transposed matrix-vector product block: random and directed element
// streams with random stalls on both channels, checked against an in-bench predictor
// depends on mtvp_pkg, the channel interfaces and matrix_transpose_vector_product_top
module tb_matrix_transpose_vector_product_top import mtvp_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   // cycles with no transaction on any channel before the run is called hung
   localparam int StallLimit   = 3000;
   localparam int RandomItems  = 1800;
   localparam int SettleCycles = 8;
   localparam int PrintCap     = 100;

   typedef struct packed {
      word_type a;
      word_type x;
   } element_type;

   logic clock;
   logic reset;

   mtvp_req_if req_if ();
   mtvp_rsp_if rsp_if ();
   mtvp_csr_if csr_if ();

   matrix_transpose_vector_product_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   // ---------------------------------------------------------------------------------------
   // predictor state: its own copy of the size register, counters and column accumulators
   // ---------------------------------------------------------------------------------------
   word_type    col_sum [MaxSize];
   int unsigned size_raw = MaxSize;
   int unsigned col_pos  = 0;
   int unsigned row_pos  = 0;
   word_type    held_x   = '0;

   result_type  sums_due [$];       // finished column sums still to be delivered
   element_type elements_pending [$];

   int          mismatch_count = 0;
   int          results_seen   = 0;
   logic        hold_rsp       = 1'b0;

   // driver and monitor bookkeeping
   element_type req_cur;
   logic        req_busy   = 1'b0;
   int          req_gap    = 0;
   int          req_burst  = 0;
   int          rsp_stall  = 0;
   int          rsp_burst  = 0;
   int          idle_count = 0;
   result_type  got_sum;

   // size 0 runs as 1, anything past the array runs as the full array
   function automatic int unsigned effective_size(input int unsigned raw);
      if (raw < 1) return 1;
      if (raw > MaxSize) return MaxSize;
      return raw;
   endfunction

   // a register write restarts the product; held vector and sums are kept
   function automatic void apply_size(input logic [SizeW-1:0] value);
      size_raw = value;
      col_pos  = 0;
      row_pos  = 0;
   endfunction

   // one accepted element: update the column sum, and on the last row queue its result
   function automatic void predict_element(input word_type a, input word_type x);
      int unsigned n;
      int unsigned col;
      word_type    acc;
      result_type  due;
      n   = effective_size(size_raw);
      col = col_pos;
      if (col >= n || row_pos >= n) begin
         col     = 0;
         row_pos = 0;
      end
      // x is only taken on the first element of a row
      if (col == 0) held_x = x;
      acc = a * held_x;
      // row 0 overwrites, later rows accumulate, all mod 2^32
      if (row_pos != 0) acc = col_sum[col] + acc;
      col_sum[col] = acc;
      if (row_pos == n - 1) begin
         due.column_index = idx_type'(col);
         due.dot_value    = acc;
         due.last_result  = (col == n - 1);
         sums_due.push_back(due);
      end
      col++;
      if (col >= n) begin
         col = 0;
         row_pos++;
         if (row_pos >= n) row_pos = 0;
      end
      col_pos = col;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PrintCap) $display("[%0t] mismatch: %s", $time, what);
   endtask

   // per-transaction random wait, with occasional bursts that never idle
   function automatic int draw_gap(inout int burst);
      if (burst > 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         burst = $urandom_range(20, 60);
         return 0;
      end
      return $urandom_range(0, 8);
   endfunction

   // mostly random words, with the sign and overflow corners mixed in
   function automatic word_type random_word();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return word_type'($urandom_range(0, 1));
         default: return $urandom;
      endcase
   endfunction

   function automatic void add_element(input word_type a, input word_type x);
      element_type e;
      e.a = a;
      e.x = x;
      elements_pending.push_back(e);
   endfunction

   function automatic void add_random_elements(input int count);
      for (int i = 0; i < count; i++) add_element(random_word(), random_word());
   endfunction

   // ---------------------------------------------------------------------------------------
   // clock
   // ---------------------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------------
   // element driver: pops the pending queue, predicts on every accepted transaction
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_busy = 1'b0;
         req_gap  = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            predict_element(req_cur.a, req_cur.x);
            req_busy = 1'b0;
            req_gap  = draw_gap(req_burst);
         end
         if (!req_busy && req_gap == 0 && elements_pending.size() != 0) begin
            req_cur  = elements_pending.pop_front();
            req_busy = 1'b1;
            req_if.matrix_value <= req_cur.a;
            req_if.vector_value <= req_cur.x;
         end else if (req_gap > 0) begin
            req_gap--;
         end
         // valid gets exactly one assignment per edge, so back-to-back items stay high
         req_if.valid <= req_busy;
      end
   end

   // ---------------------------------------------------------------------------------------
   // result monitor: random ready stalls plus the long hold-off, compares against sums_due
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            got_sum.column_index = rsp_if.column_index;
            got_sum.dot_value    = rsp_if.dot_value;
            got_sum.last_result  = rsp_if.last_result;
            if (sums_due.size() == 0) begin
               report_mismatch($sformatf("unexpected result column %0d value %0d",
                                         got_sum.column_index, got_sum.dot_value));
            end else begin
               automatic result_type want = sums_due.pop_front();
               if (got_sum.column_index !== want.column_index)
                  report_mismatch($sformatf("column_index got %0d want %0d",
                                            got_sum.column_index, want.column_index));
               if (got_sum.dot_value !== want.dot_value)
                  report_mismatch($sformatf("dot_value on column %0d got %0d want %0d",
                                            want.column_index, got_sum.dot_value,
                                            want.dot_value));
               if (got_sum.last_result !== want.last_result)
                  report_mismatch($sformatf("last_result on column %0d got %0b want %0b",
                                            want.column_index, got_sum.last_result,
                                            want.last_result));
            end
            rsp_stall = draw_gap(rsp_burst);
         end
         rsp_if.ready <= (rsp_stall == 0) && !hold_rsp;
         if (rsp_stall > 0) rsp_stall--;
      end
   end

   // ---------------------------------------------------------------------------------------
   // long receiver hold-off: the sender keeps offering, so the output queue fills and
   // the block has to back-pressure its input
   // ---------------------------------------------------------------------------------------
   initial begin
      wait (results_seen >= 40);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (400) @(posedge clock);
      hold_rsp <= 1'b0;
      wait (results_seen >= 300);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (400) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // ---------------------------------------------------------------------------------------
   // watchdog: any transaction on any channel resets the count
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         idle_count <= 0;
      end else if (idle_count >= StallLimit) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_count <= idle_count + 1;
      end
   end

   // ---------------------------------------------------------------------------------------
   // stimulus sequencing
   // ---------------------------------------------------------------------------------------

   // size register write; only issued while the block is drained
   task automatic write_size(input logic [SizeW-1:0] value);
      @(posedge clock);
      csr_if.valid       <= 1'b1;
      csr_if.size_in_use <= value;
      do @(posedge clock); while (!(csr_if.valid && csr_if.ready));
      csr_if.valid <= 1'b0;
      apply_size(value);
      @(negedge clock);
   endtask

   // all elements sent, all sums back, then SettleCycles more for anything still in flight
   task automatic wait_idle();
      do @(negedge clock);
      while (elements_pending.size() != 0 || req_busy || sums_due.size() != 0);
      repeat (SettleCycles) @(negedge clock);
   endtask

   initial begin
      int          random_sent;
      int unsigned size_pick;
      int unsigned n;
      int          count;
      int          pick;

      req_if.valid        = 1'b0;
      req_if.matrix_value = '0;
      req_if.vector_value = '0;
      rsp_if.ready        = 1'b0;
      csr_if.valid        = 1'b0;
      csr_if.size_in_use  = '0;
      reset               = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset size is the full array: a few elements, none of them finishes a column
      add_element(32'h7FFF_FFFF, 32'h8000_0000);
      add_element(32'h8000_0000, 32'h7FFF_FFFF);
      add_element(32'hFFFF_FFFF, 32'h0000_0000);
      wait_idle();

      // size 0 runs as 1: every element is its own last row and last column
      write_size('0);
      add_element(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      add_element(32'h8000_0000, 32'h8000_0000);
      add_element(32'hFFFF_FFFF, 32'h8000_0000);
      add_element(32'h0000_0000, 32'hFFFF_FFFF);
      wait_idle();

      // all-ones size clamps to the full array; a partial product gets dropped by the
      // next write
      write_size({SizeW{1'b1}});
      add_random_elements(2);
      wait_idle();

      // one full 2x2 product, then row 0 of another left unfinished
      write_size(SizeW'(2));
      add_random_elements(6);
      wait_idle();

      // write mid-product restarts cleanly at size 3
      write_size(SizeW'(3));
      add_random_elements(9);
      wait_idle();

      // random part: mostly complete products at small sizes, some cut short
      random_sent = 0;
      while (random_sent < RandomItems) begin
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            size_pick = 0;
         end else if (pick < 10) begin
            case ($urandom_range(0, 2))
               0: size_pick = MaxSize;
               1: size_pick = (1 << SizeW) - 1;
               default: size_pick = $urandom_range(17, (1 << SizeW) - 1);
            endcase
         end else if (pick < 75) begin
            size_pick = $urandom_range(1, 6);
         end else begin
            size_pick = $urandom_range(7, 16);
         end
         write_size(SizeW'(size_pick));
         n = effective_size(size_pick);
         if (n > 16)
            count = $urandom_range(1, 40);          // large sizes only ever see a fragment
         else if ($urandom_range(0, 5) == 0)
            count = $urandom_range(1, n * n);       // product abandoned part way
         else
            count = n * n * $urandom_range(1, 3);   // back-to-back complete products
         // keep the total near the item budget
         if (count > RandomItems - random_sent)
            count = RandomItems - random_sent;
         add_random_elements(count);
         random_sent += count;
         wait_idle();
      end

      repeat (SettleCycles) @(negedge clock);
      if (sums_due.size() != 0)
         report_mismatch($sformatf("%0d results never delivered", sums_due.size()));
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
